/* rtl/rbmc_pkg.sv */
// Package for the relay bank mode controller: transaction payload types,
// mode and register index codes, reset values and the rotation search function.
// No dependencies.
`default_nettype none

package rbmc_pkg;

  // Payload of one input transaction
  typedef struct packed {
    logic       req_type;
    logic [9:0] command_offset;
  } in_item_t;

  // Payload of one result transaction
  typedef struct packed {
    logic [7:0] bank_c_drive;
    logic [7:0] bank_a_drive;
    logic       rotating;
  } out_item_t;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_EXCL       = 2'd0,
    MODE_EXCL_CLEAR = 2'd1,
    MODE_INDEP      = 2'd2,
    MODE_ROTATE     = 2'd3
  } mode_t;

  // Request kinds
  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECONDS  = 3'd4;

  // Register reset values
  localparam logic       POLARITY_RST = 1'b1;
  localparam logic [7:0] MASK_RST     = 8'hFF;
  localparam logic [7:0] SECONDS_RST  = 8'd1;

  // Command limits
  localparam logic [9:0] CMD_MAX     = 10'd31;
  localparam logic [3:0] LAST_RELAY  = 4'd15;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // First set mask bit at or after pos, cyclic; an empty mask acts as bit 0
  function automatic logic [2:0] pick_next(input logic [7:0] mask, input logic [2:0] pos);
    logic [7:0] m;
    logic [2:0] idx;
    logic       found;
    m     = (mask == 8'd0) ? 8'd1 : mask;
    idx   = pos;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!found && m[pos + 3'(k)]) begin
        idx   = pos + 3'(k);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/rbmc_ifs.sv */
// Valid/ready channel interfaces for the relay bank mode controller.
// Depends on rbmc_pkg for the payload types.
`default_nettype none

interface rbmc_in_if
  import rbmc_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rbmc_out_if
  import rbmc_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/relay_bank_mode_controller.sv */
// Relay bank mode controller top level: command/tick decode, relay state and
// round-robin rotation. Depends on rbmc_pkg and the channel interfaces in rbmc_ifs.
//
// Usage:
//   in_chan carries one transaction per request: req_type 0 is an accessory
//   command (command_offset = relay * 2 + operation bit), req_type 1 is a
//   one-second tick. Every accepted transaction yields exactly one result
//   on out_chan with the bank C and bank A drive bits and the rotating flag,
//   taken after that request has been applied.
//   An accepted request sits in the input register; when it leaves, the
//   state update is applied and the result register is loaded with the
//   result. Throughput is one transaction per cycle while the receiver
//   takes results; the input register and the result register form a
//   two-stage pipe, so a new request is taken while a finished result waits
//   for the receiver.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_chan.ready drops until the result is taken.
//   The cfg port writes one register per cycle at cfg_we; write only while
//   no transaction is in flight. Writing the mode register also sets the
//   rotating flag to (mode == round-robin).
//   Synchronous active-low reset clears all relay state, the pipe valid flags
//   and the configuration to its defaults; no clearing pass is needed.
`default_nettype none

module relay_bank_mode_controller
  import rbmc_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  rbmc_in_if.sink              in_chan,
  rbmc_out_if.source           out_chan,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_idx,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  mode_t      mode_r;
  logic       polarity_r;
  logic [7:0] mask_c_r;
  logic [7:0] mask_a_r;
  logic [7:0] seconds_r;

  // Relay state
  logic [7:0] drive_c_r, drive_c_nxt;
  logic [7:0] drive_a_r, drive_a_nxt;
  logic [4:0] last_cmd_r, last_cmd_nxt;
  logic       rotate_r, rotate_nxt;
  logic [2:0] next_c_r, next_c_nxt;
  logic [2:0] next_a_r, next_a_nxt;
  logic [7:0] count_r, count_nxt;

  // Pipe registers
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic advance;
  logic in_fire;

  assign advance = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Apply one request to the relay state
  always_comb begin
    logic [4:0] cmd;
    logic [3:0] relay;
    logic [2:0] pos_a;
    logic       set;
    logic [7:0] bit_c;
    logic [7:0] bit_a;
    logic [7:0] count_inc;
    logic [7:0] interval;
    logic [2:0] ia;
    logic [2:0] ic;

    drive_c_nxt  = drive_c_r;
    drive_a_nxt  = drive_a_r;
    last_cmd_nxt = last_cmd_r;
    rotate_nxt   = rotate_r;
    next_c_nxt   = next_c_r;
    next_a_nxt   = next_a_r;
    count_nxt    = count_r;

    cmd       = s1_data_r.command_offset[4:0];
    relay     = cmd[4:1];
    pos_a     = ~relay[2:0];
    set       = (cmd[0] == polarity_r);
    bit_c     = 8'd1 << relay[2:0];
    bit_a     = 8'd1 << pos_a;
    count_inc = (count_r != COUNT_MAX) ? count_r + 8'd1 : count_r;
    interval  = (seconds_r == 8'd0) ? 8'd1 : seconds_r;
    ia        = pick_next(mask_a_r, next_a_r);
    ic        = pick_next(mask_c_r, next_c_r);

    if (s1_data_r.req_type == REQ_TICK) begin
      // Count seconds; step the rotation at the interval
      if (count_inc >= interval) begin
        count_nxt = 8'd0;
        if (rotate_r) begin
          next_a_nxt  = ia + 3'd1;
          next_c_nxt  = ic + 3'd1;
          drive_a_nxt = 8'd1 << (3'd7 - ia);
          drive_c_nxt = 8'd1 << ic;
        end
      end else begin
        count_nxt = count_inc;
      end
    end else if (s1_data_r.command_offset <= CMD_MAX && cmd != last_cmd_r) begin
      last_cmd_nxt = cmd;
      if (!relay[3]) begin
        // Bank C
        if (set) begin
          case (mode_r)
            MODE_EXCL: begin
              drive_c_nxt = bit_c;
              rotate_nxt  = 1'b0;
            end
            MODE_EXCL_CLEAR: drive_c_nxt = bit_c;
            MODE_INDEP:      drive_c_nxt = drive_c_r | bit_c;
            default:         drive_c_nxt = drive_c_r;
          endcase
        end else if (mode_r == MODE_EXCL_CLEAR || mode_r == MODE_INDEP) begin
          drive_c_nxt = drive_c_r & ~bit_c;
        end
      end else begin
        // Bank A, bits reversed
        if (set) begin
          case (mode_r)
            MODE_EXCL: begin
              drive_a_nxt = bit_a;
              rotate_nxt  = 1'b0;
            end
            MODE_EXCL_CLEAR: drive_a_nxt = bit_a;
            MODE_INDEP:      drive_a_nxt = drive_a_r | bit_a;
            default:         drive_a_nxt = drive_a_r;
          endcase
        end else if (mode_r == MODE_EXCL) begin
          // A clear on the last relay starts rotation
          if (relay == LAST_RELAY) rotate_nxt = 1'b1;
        end else if (mode_r == MODE_EXCL_CLEAR || mode_r == MODE_INDEP) begin
          drive_a_nxt = drive_a_r & ~bit_a;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_EXCL;
      polarity_r <= POLARITY_RST;
      mask_c_r   <= MASK_RST;
      mask_a_r   <= MASK_RST;
      seconds_r  <= SECONDS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:     mode_r     <= mode_t'(cfg_data[1:0]);
        REG_POLARITY: polarity_r <= cfg_data[0];
        REG_MASK_C:   mask_c_r   <= cfg_data;
        REG_MASK_A:   mask_a_r   <= cfg_data;
        REG_SECONDS:  seconds_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Relay state: advance with the pipe, mode writes reload the rotating flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_c_r  <= 8'd0;
      drive_a_r  <= 8'd0;
      last_cmd_r <= 5'd0;
      rotate_r   <= 1'b0;
      next_c_r   <= 3'd0;
      next_a_r   <= 3'd0;
      count_r    <= 8'd0;
    end else if (cfg_we && cfg_idx == REG_MODE) begin
      rotate_r <= (cfg_data[1:0] == MODE_ROTATE);
    end else if (advance) begin
      drive_c_r  <= drive_c_nxt;
      drive_a_r  <= drive_a_nxt;
      last_cmd_r <= last_cmd_nxt;
      rotate_r   <= rotate_nxt;
      next_c_r   <= next_c_nxt;
      next_a_r   <= next_a_nxt;
      count_r    <= count_nxt;
    end
  end

  // Pipe control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipe payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_chan.data;
    end
    if (advance) begin
      out_data_r.bank_c_drive <= drive_c_nxt;
      out_data_r.bank_a_drive <= drive_a_nxt;
      out_data_r.rotating     <= rotate_nxt;
    end
  end

  // Input is never stalled while the result register is free
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with free result register");

  // A result appears only after a request left the input register
  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result without request");

  // A rotation step leaves exactly one relay closed per bank
  a_rotate_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_data_r.req_type == REQ_TICK && rotate_r && count_nxt == 8'd0
     && !(cfg_we && cfg_idx == REG_MODE))
    |=> $onehot(drive_c_r) && $onehot(drive_a_r))
    else $error("rotation step not one-hot");

  // Out-of-range commands change no relay state
  a_ignore_range: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_data_r.req_type == REQ_COMMAND && s1_data_r.command_offset > CMD_MAX
     && !cfg_we)
    |=> $stable(drive_c_r) && $stable(drive_a_r) && $stable(last_cmd_r) && $stable(rotate_r))
    else $error("out-of-range command changed state");

endmodule

`default_nettype wire
